FILE: rtl/gra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gra_pkg;

  // Field widths
  localparam int GRA_SAMPLE_W   = 16;
  localparam int GRA_BIAS_W     = 24;
  localparam int GRA_DEADBAND_W = 15;
  localparam int GRA_FRAC_W     = 8;
  localparam int GRA_QUOT_W     = 16;  // integer part of the average, up to 32768
  localparam int GRA_PITCH_W    = 24;
  localparam int GRA_YAW_W      = 25;

  // Configuration port
  localparam int GRA_ADDR_W = 4;
  localparam int GRA_DATA_W = 32;

  // Defaults
  localparam int GRA_WINDOW_LEN = 8;
  localparam logic [GRA_DEADBAND_W-1:0] GRA_DEADBAND_RST = 15'd10;

  // Saturation limits of a debiased sample
  localparam logic signed [GRA_SAMPLE_W-1:0] GRA_SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [GRA_SAMPLE_W-1:0] GRA_SAMPLE_MIN = 16'sh8000;

  // Register map (word index)
  typedef enum logic [1:0] {
    REG_PITCH_BIAS = 2'd0,
    REG_YAW_BIAS   = 2'd1,
    REG_DEADBAND   = 2'd2,
    REG_AXIS_SEL   = 2'd3
  } reg_idx_t;

  // Load enables of the averaging stages
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } avg_en_t;

  // Unsigned average split into integer and fraction, plus sign of the sum
  typedef struct packed {
    logic                  neg;
    logic [GRA_QUOT_W-1:0] quot;
    logic [GRA_FRAC_W-1:0] frac;
  } avg_res_t;

endpackage

`default_nettype wire

FILE: rtl/gra_debias.sv
`timescale 1ns / 1ps
`default_nettype none

module gra_debias
  import gra_pkg::*;
(
  input  wire logic signed [GRA_SAMPLE_W-1:0] sample,
  input  wire logic signed [GRA_BIAS_W-1:0]   bias,
  output logic signed [GRA_SAMPLE_W-1:0]      result
);

  logic signed [GRA_BIAS_W:0]   diff;
  logic signed [GRA_SAMPLE_W:0] quot;

  // Q8 difference, sample scaled up by 256
  assign diff = $signed({sample[GRA_SAMPLE_W-1], sample, 8'b0})
              - $signed({bias[GRA_BIAS_W-1], bias});

  // Drop fraction toward zero: floor, plus one for a negative value with a fraction
  assign quot = $signed(diff[GRA_BIAS_W:GRA_FRAC_W])
              + $signed({{GRA_SAMPLE_W{1'b0}}, (diff[GRA_BIAS_W] && (|diff[GRA_FRAC_W-1:0]))});

  // Clamp to 16 bits
  always_comb begin
    if (quot[GRA_SAMPLE_W] != quot[GRA_SAMPLE_W-1]) begin
      result = quot[GRA_SAMPLE_W] ? GRA_SAMPLE_MIN : GRA_SAMPLE_MAX;
    end else begin
      result = quot[GRA_SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gra_window.sv
`timescale 1ns / 1ps
`default_nettype none

module gra_window
  import gra_pkg::*;
#(
  parameter int WINDOW_LEN = GRA_WINDOW_LEN,
  parameter int SUM_W      = GRA_SAMPLE_W + $clog2(WINDOW_LEN)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           shift_en,
  input  wire logic signed [GRA_SAMPLE_W-1:0] sample,
  output logic signed [SUM_W-1:0]             sum
);

  logic signed [GRA_SAMPLE_W-1:0] taps [WINDOW_LEN];
  logic signed [SUM_W-1:0]        add_ext;
  logic signed [SUM_W-1:0]        sub_ext;
  logic signed [SUM_W-1:0]        sum_next;

  // Running sum: add the newest sample, drop the oldest tap
  assign add_ext  = SUM_W'(sample);
  assign sub_ext  = SUM_W'(taps[WINDOW_LEN-1]);
  assign sum_next = sum + add_ext - sub_ext;

  // Shift line holding the last WINDOW_LEN samples
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        taps[i] <= '0;
      end
      sum <= '0;
    end else if (shift_en) begin
      taps[0] <= sample;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        taps[i] <= taps[i-1];
      end
      sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gra_avg.sv
`timescale 1ns / 1ps
`default_nettype none

module gra_avg
  import gra_pkg::*;
#(
  parameter int WINDOW_LEN = GRA_WINDOW_LEN,
  parameter int SUM_W      = GRA_SAMPLE_W + $clog2(WINDOW_LEN)
) (
  input  wire logic                    clk,
  input  wire avg_en_t                 en,
  input  wire logic signed [SUM_W-1:0] sum,
  output avg_res_t                     res
);

  // Reciprocal constants: floor(x / N) = (x * R) >> S, exact for x below 2^k
  // with S = k + clog2(N) and R = ceil(2^S / N).
  localparam int     LOG_N = $clog2(WINDOW_LEN);
  localparam int     S1    = SUM_W + LOG_N;
  localparam longint R1    = ((64'sd1 <<< S1) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int     X2_W  = LOG_N + GRA_FRAC_W;
  localparam int     S2    = X2_W + LOG_N;
  localparam longint R2    = ((64'sd1 <<< S2) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int     P1_W  = SUM_W + S1;
  localparam int     P2_W  = X2_W + S2;

  localparam logic [S1-1:0]    RECIP1 = S1'(R1);
  localparam logic [S2-1:0]    RECIP2 = S2'(R2);
  localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(WINDOW_LEN);

  logic                  neg3, neg4, neg5, neg6;
  logic [SUM_W-1:0]      mag3, mag4;
  logic [GRA_QUOT_W-1:0] quot4, quot5, quot6;
  logic [LOG_N-1:0]      rem5;
  logic [GRA_FRAC_W-1:0] frac6;

  logic [SUM_W-1:0]      mag_next;
  logic [P1_W-1:0]       prod1;
  logic [SUM_W-1:0]      rem_full;
  logic [X2_W-1:0]       rem_scaled;
  logic [P2_W-1:0]       prod2;

  // Stage 3: sign and magnitude of the window sum
  assign mag_next = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      neg3 <= sum[SUM_W-1];
      mag3 <= mag_next;
    end
  end

  // Stage 4: integer quotient by reciprocal multiply
  assign prod1 = P1_W'(mag3) * P1_W'(RECIP1);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      neg4  <= neg3;
      mag4  <= mag3;
      quot4 <= prod1[S1 +: GRA_QUOT_W];
    end
  end

  // Stage 5: remainder
  assign rem_full = mag4 - SUM_W'(quot4) * DIVISOR;

  always_ff @(posedge clk) begin
    if (en.s5) begin
      neg5  <= neg4;
      quot5 <= quot4;
      rem5  <= rem_full[LOG_N-1:0];
    end
  end

  // Stage 6: eight fraction bits from remainder * 256 / N
  assign rem_scaled = {rem5, {GRA_FRAC_W{1'b0}}};
  assign prod2      = P2_W'(rem_scaled) * P2_W'(RECIP2);

  always_ff @(posedge clk) begin
    if (en.s6) begin
      neg6  <= neg5;
      quot6 <= quot5;
      frac6 <= prod2[S2 +: GRA_FRAC_W];
    end
  end

  assign res.neg  = neg6;
  assign res.quot = quot6;
  assign res.frac = frac6;

endmodule

`default_nettype wire

FILE: rtl/gyro_rate_moving_average_top.sv
// Throughput: one request per cycle while out_stall is low; seven pipeline stages,
// each with its own valid bit, so a stalled result holds only the stages behind it
// that are full.
// Reset (synchronous, rst high): clears the sample windows, running sums and valid
// bits; biases and axis select go to 0, deadband to 10.
`timescale 1ns / 1ps
`default_nettype none

module gyro_rate_moving_average_top
  import gra_pkg::*;
#(
  parameter int WINDOW_LEN = GRA_WINDOW_LEN
) (
  input  wire logic                           clk,
  input  wire logic                           rst,

  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [GRA_SAMPLE_W-1:0] rate_x,
  input  wire logic signed [GRA_SAMPLE_W-1:0] rate_y,
  input  wire logic signed [GRA_SAMPLE_W-1:0] rate_z,

  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [GRA_YAW_W-1:0]         yaw_rate,
  output logic signed [GRA_PITCH_W-1:0]       pitch_rate,

  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [GRA_ADDR_W-1:0]          paddr,
  input  wire logic [GRA_DATA_W-1:0]          pwdata,
  output logic [GRA_DATA_W-1:0]               prdata,
  output logic                                pready
);

  localparam int SUM_W = GRA_SAMPLE_W + $clog2(WINDOW_LEN);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(32767 * WINDOW_LEN);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-32768 * WINDOW_LEN);

  // Configuration registers
  logic signed [GRA_BIAS_W-1:0] pitch_bias;
  logic signed [GRA_BIAS_W-1:0] yaw_bias;
  logic [GRA_DEADBAND_W-1:0]    deadband;
  logic                         pitch_axis_sel;

  reg_idx_t reg_idx;
  logic     cfg_wr;

  // Pipeline control, stage 1 through 7 (7 is the output register)
  logic [7:1] vld;
  logic [8:1] rdy;

  logic signed [GRA_SAMPLE_W-1:0] pitch_raw;
  logic signed [GRA_SAMPLE_W-1:0] pitch_db;
  logic signed [GRA_SAMPLE_W-1:0] yaw_db;
  logic signed [GRA_SAMPLE_W-1:0] s1_pitch;
  logic signed [GRA_SAMPLE_W-1:0] s1_yaw;

  logic signed [SUM_W-1:0] pitch_sum;
  logic signed [SUM_W-1:0] yaw_sum;
  logic                    shift_en;

  avg_en_t  avg_en;
  avg_res_t pitch_res;
  avg_res_t yaw_res;

  logic [GRA_YAW_W-1:0] pitch_mag;
  logic [GRA_YAW_W-1:0] yaw_mag;
  logic                 pitch_zero;
  logic                 yaw_zero;

  // APB register access
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_bias     <= '0;
      yaw_bias       <= '0;
      deadband       <= GRA_DEADBAND_RST;
      pitch_axis_sel <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PITCH_BIAS: pitch_bias     <= pwdata[GRA_BIAS_W-1:0];
        REG_YAW_BIAS:   yaw_bias       <= pwdata[GRA_BIAS_W-1:0];
        REG_DEADBAND:   deadband       <= pwdata[GRA_DEADBAND_W-1:0];
        REG_AXIS_SEL:   pitch_axis_sel <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PITCH_BIAS: prdata = {{(GRA_DATA_W-GRA_BIAS_W){pitch_bias[GRA_BIAS_W-1]}}, pitch_bias};
      REG_YAW_BIAS:   prdata = {{(GRA_DATA_W-GRA_BIAS_W){yaw_bias[GRA_BIAS_W-1]}}, yaw_bias};
      REG_DEADBAND:   prdata = {{(GRA_DATA_W-GRA_DEADBAND_W){1'b0}}, deadband};
      REG_AXIS_SEL:   prdata = {{(GRA_DATA_W-1){1'b0}}, pitch_axis_sel};
      default:        prdata = '0;
    endcase
  end

  // Ready chain: a stage loads when empty or when the next one loads
  always_comb begin
    rdy[8] = !out_stall;
    for (int i = 7; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int i = 2; i <= 7; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign out_valid = vld[7];

  // Stage 1: axis select and bias removal
  assign pitch_raw = pitch_axis_sel ? rate_y : rate_x;

  gra_debias u_pitch_debias (
    .sample (pitch_raw),
    .bias   (pitch_bias),
    .result (pitch_db)
  );

  gra_debias u_yaw_debias (
    .sample (rate_z),
    .bias   (yaw_bias),
    .result (yaw_db)
  );

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_pitch <= pitch_db;
      s1_yaw   <= yaw_db;
    end
  end

  // Stage 2: window shift and running sums
  assign shift_en = rdy[2] && vld[1];

  gra_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_pitch_window (
    .clk      (clk),
    .rst      (rst),
    .shift_en (shift_en),
    .sample   (s1_pitch),
    .sum      (pitch_sum)
  );

  gra_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_yaw_window (
    .clk      (clk),
    .rst      (rst),
    .shift_en (shift_en),
    .sample   (s1_yaw),
    .sum      (yaw_sum)
  );

  // Stages 3 to 6: divide by the window length
  assign avg_en.s3 = rdy[3];
  assign avg_en.s4 = rdy[4];
  assign avg_en.s5 = rdy[5];
  assign avg_en.s6 = rdy[6];

  gra_avg #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_pitch_avg (
    .clk (clk),
    .en  (avg_en),
    .sum (pitch_sum),
    .res (pitch_res)
  );

  gra_avg #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_yaw_avg (
    .clk (clk),
    .en  (avg_en),
    .sum (yaw_sum),
    .res (yaw_res)
  );

  // Stage 7: deadband, sign, yaw negation
  assign pitch_zero = pitch_res.quot < {1'b0, deadband};
  assign yaw_zero   = yaw_res.quot < {1'b0, deadband};
  assign pitch_mag  = pitch_zero ? '0 : {1'b0, pitch_res.quot, pitch_res.frac};
  assign yaw_mag    = yaw_zero ? '0 : {1'b0, yaw_res.quot, yaw_res.frac};

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      pitch_rate <= pitch_res.neg ? GRA_PITCH_W'(-pitch_mag) : GRA_PITCH_W'(pitch_mag);
      yaw_rate   <= yaw_res.neg ? yaw_mag : -yaw_mag;
    end
  end

  // Checks
  property p_pitch_sum_range;
    @(posedge clk) disable iff (rst)
      (pitch_sum <= SUM_MAX) && (pitch_sum >= SUM_MIN);
  endproperty
  a_pitch_sum_range: assert property (p_pitch_sum_range)
    else $error("pitch window sum out of range");

  property p_yaw_sum_range;
    @(posedge clk) disable iff (rst)
      (yaw_sum <= SUM_MAX) && (yaw_sum >= SUM_MIN);
  endproperty
  a_yaw_sum_range: assert property (p_yaw_sum_range)
    else $error("yaw window sum out of range");

  property p_quot_range;
    @(posedge clk) disable iff (rst)
      vld[6] |-> ((pitch_res.quot <= 16'd32768) && (yaw_res.quot <= 16'd32768));
  endproperty
  a_quot_range: assert property (p_quot_range)
    else $error("average quotient out of range");

  property p_full_stall;
    @(posedge clk) disable iff (rst)
      ((&vld) && out_stall) |-> in_stall;
  endproperty
  a_full_stall: assert property (p_full_stall)
    else $error("request taken while pipeline full and output stalled");

endmodule

`default_nettype wire
